@@ rtl/core/drs_pkg.sv @@
`default_nettype none
package drs_pkg;

  localparam int SPS_DEF   = 4;
  localparam int DEPTH_DEF = 16;
  localparam int TFB_DEF   = 24;

  // register index codes
  localparam logic [2:0] REG_TIME_STEP  = 3'd0;
  localparam logic [2:0] REG_START_TIME = 3'd1;
  localparam logic [2:0] REG_ECHO_RE    = 3'd2;
  localparam logic [2:0] REG_ECHO_IM    = 3'd3;
  localparam logic [2:0] REG_PHASE_STEP = 3'd4;
  localparam logic [2:0] REG_GAIN       = 3'd5;
  localparam logic [2:0] REG_DC_RE      = 3'd6;
  localparam logic [2:0] REG_DC_IM      = 3'd7;

  localparam logic [25:0] TIME_STEP_RST  = 26'd16777216;
  localparam logic [31:0] START_TIME_RST = 32'd134217728;
  localparam logic [15:0] GAIN_RST       = 16'd4096;

  // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for x below 2^18
  localparam logic [19:0] DIV3_MUL   = 20'd699051;
  localparam int          DIV3_SHIFT = 21;

  // odd sine polynomial, Q30
  localparam logic signed [32:0] SIN_A9 = 33'sd172272;
  localparam logic signed [32:0] SIN_A [4] = '{
    -33'sd5026995, 33'sd85569306, -33'sd693598668, 33'sd1686629713
  };

  typedef struct packed {
    logic       store;
    logic       coef1;
    logic       coef2;
    logic       coef3;
    logic       sin_start;
    logic       rd;
    logic [1:0] rd_idx;
    logic       mac;
    logic       rnd;
    logic       echo;
    logic       mix;
    logic       gain;
    logic       adv;
    logic       load_out;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic win_rdy;
    logic sin_done;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/drs_sine.sv @@
`default_nettype none
module drs_sine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] x,
  output logic             done,
  output logic [15:0]      r
);

  logic [30:0]        z_r;
  logic [30:0]        w_r;
  logic signed [32:0] p_r;
  logic [2:0]         step_r;
  logic               busy_r;
  logic               done_r;
  logic [15:0]        r_r;

  logic [61:0]        zz;
  logic signed [64:0] pw;
  logic signed [64:0] pz;
  logic signed [34:0] v;
  logic signed [19:0] rr;

  always_comb begin
    zz = {31'b0, z_r} * {31'b0, z_r};
    pw = p_r * $signed({1'b0, w_r});
    pz = p_r * $signed({1'b0, z_r});
    v  = $signed(pz[64:30]) + 35'sd16384;
    rr = $signed(v[34:15]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 3'd1;
      if (step_r == 3'd5) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z_r <= x;
    end else if (busy_r) begin
      unique case (step_r)
        3'd0: begin
          w_r <= zz[60:30];
          p_r <= drs_pkg::SIN_A9;
        end
        3'd1, 3'd2, 3'd3, 3'd4: begin
          p_r <= drs_pkg::SIN_A[step_r[1:0] - 2'd1] + $signed(pw[62:30]);
        end
        default: begin
          if (rr < 0) begin
            r_r <= '0;
          end else if (rr > 20'sd32767) begin
            r_r <= 16'd32767;
          end else begin
            r_r <= rr[15:0];
          end
        end
      endcase
    end
  end

  assign done = done_r;
  assign r    = r_r;

endmodule
`default_nettype wire

@@ rtl/core/drs_datapath.sv @@
`default_nettype none
module drs_datapath #(
  parameter int SPS   = drs_pkg::SPS_DEF,
  parameter int DEPTH = drs_pkg::DEPTH_DEF,
  parameter int TFB   = drs_pkg::TFB_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire drs_pkg::dp_cmd_t   cmd,
  output drs_pkg::dp_sts_t        sts,
  input  wire logic signed [15:0] in_i,
  input  wire logic signed [15:0] in_q,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_q,
  output logic                    out_last
);

  localparam int TW = 32 + TFB;
  localparam int AW = $clog2(DEPTH);

  logic [25:0]        time_step_r;
  logic signed [15:0] echo_re_r, echo_im_r, dc_re_r, dc_im_r;
  logic [31:0]        phase_step_r;
  logic [15:0]        gain_r;

  logic [TW-1:0]      time_r;
  logic [31:0]        phase_r;
  logic [31:0]        seen_r;
  logic [AW-1:0]      wptr_r;

  logic [31:0]        hist_mem [DEPTH];
  logic [31:0]        rdm_r, rde_r;
  logic               vm_r, ve_r;
  logic [1:0]         idx_r;

  logic [33:0]        a_r;
  logic [34:0]        b_r;
  logic [53:0]        p_r [4];
  logic signed [18:0] c_r [4];
  logic signed [36:0] acc_r [4];
  logic signed [19:0] ip_r [4];
  logic signed [21:0] sr_r, si_r;
  logic signed [24:0] mr_r, mi_r;
  logic signed [15:0] res_i_r, res_q_r;
  logic signed [15:0] out_i_r, out_q_r;
  logic               out_last_r;

  logic [31:0]        ti;
  logic [TFB+15:0]    uext;
  logic [16:0]        u17, om17, op17;
  logic [17:0]        tm18;
  logic [53:0]        t1, t2;
  logic signed [18:0] c_nxt [4];
  logic [34:0]        km, ke;
  logic [AW:0]        fm, fe;
  logic signed [15:0] ys [4];
  logic signed [36:0] re_t, im_t;
  logic signed [16:0] sin17, cos17, lr, li;
  logic signed [39:0] mr_t, mi_t;
  logic signed [41:0] gr_t, gi_t;
  logic [30:0]        gr_s, gi_s;
  logic               sin_done, cos_done;
  logic [15:0]        sin_v, cos_v;

  function automatic logic [AW:0] locate(input logic [34:0] k, input logic [31:0] seen,
                                         input logic [AW-1:0] wptr);
    logic [34:0] d;
    logic [AW:0] dl, w, a;
    logic        ok;
    d  = {3'b000, seen} - k;
    dl = d[AW:0];
    w  = {1'b0, wptr};
    ok = !k[34] && !d[34] && (d != '0) && (d <= 35'(DEPTH));
    a  = (w >= dl) ? (w - dl) : (w + (AW+1)'(DEPTH) - dl);
    return {ok, a[AW-1:0]};
  endfunction

  function automatic logic signed [15:0] sat16(input logic [30:0] v);
    logic signed [30:0] s;
    s = $signed(v);
    if (s > 31'sd32767) begin
      return 16'sh7fff;
    end else if (s < -31'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  always_comb begin
    ti   = time_r[TW-1:TFB];
    uext = {time_r[TFB-1:0], 16'b0};
    u17  = {1'b0, uext[TFB+15:TFB]};
    om17 = 17'd65536 - u17;
    op17 = 17'd65536 + u17;
    tm18 = 18'd131072 - {1'b0, u17};
    t1   = {19'b0, b_r} * {37'b0, om17};
    t2   = {19'b0, b_r} * {37'b0, u17};
    for (int j = 0; j < 4; j++) begin
      logic [53:0] ps;
      logic [40:0] m;
      ps = p_r[j] + 54'h3_0000_0000;
      m  = {20'b0, ps[53:33]} * {21'b0, drs_pkg::DIV3_MUL};
      if (j == 0 || j == 3) begin
        c_nxt[j] = -$signed({1'b0, m[drs_pkg::DIV3_SHIFT+17:drs_pkg::DIV3_SHIFT]});
      end else begin
        c_nxt[j] = $signed({1'b0, m[drs_pkg::DIV3_SHIFT+17:drs_pkg::DIV3_SHIFT]});
      end
    end
    km = {3'b000, ti} - 35'd1 + {33'b0, cmd.rd_idx};
    ke = km - 35'(SPS);
    fm = locate(km, seen_r, wptr_r);
    fe = locate(ke, seen_r, wptr_r);
    ys[0] = vm_r ? $signed(rdm_r[15:0])  : 16'sd0;
    ys[1] = vm_r ? $signed(rdm_r[31:16]) : 16'sd0;
    ys[2] = ve_r ? $signed(rde_r[15:0])  : 16'sd0;
    ys[3] = ve_r ? $signed(rde_r[31:16]) : 16'sd0;
    re_t = echo_re_r * ip_r[2] - echo_im_r * ip_r[3] + 37'sd16384;
    im_t = echo_re_r * ip_r[3] + echo_im_r * ip_r[2] + 37'sd16384;
    sin17 = $signed({1'b0, sin_v});
    cos17 = $signed({1'b0, cos_v});
    unique case (phase_r[31:30])
      2'd0:    begin lr = cos17;  li = sin17;  end
      2'd1:    begin lr = -sin17; li = cos17;  end
      2'd2:    begin lr = -cos17; li = -sin17; end
      default: begin lr = sin17;  li = -cos17; end
    endcase
    mr_t = sr_r * lr - si_r * li + 40'sd16384;
    mi_t = sr_r * li + si_r * lr + 40'sd16384;
    gr_t = mr_r * $signed({1'b0, gain_r}) + 42'sd2048;
    gi_t = mi_r * $signed({1'b0, gain_r}) + 42'sd2048;
    gr_s = {gr_t[41], gr_t[41:12]} + {{15{dc_re_r[15]}}, dc_re_r};
    gi_s = {gi_t[41], gi_t[41:12]} + {{15{dc_im_r[15]}}, dc_im_r};
  end

  assign sts.win_rdy  = ({2'b00, ti} + 34'd3) <= {2'b00, seen_r};
  assign sts.sin_done = sin_done && cos_done;

  drs_sine u_sin (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sin_start),
    .x     ({1'b0, phase_r[29:0]}),
    .done  (sin_done),
    .r     (sin_v)
  );

  drs_sine u_cos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sin_start),
    .x     (31'h4000_0000 - {1'b0, phase_r[29:0]}),
    .done  (cos_done),
    .r     (cos_v)
  );

  // configuration, time, phase, sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r  <= drs_pkg::TIME_STEP_RST;
      echo_re_r    <= '0;
      echo_im_r    <= '0;
      phase_step_r <= '0;
      gain_r       <= drs_pkg::GAIN_RST;
      dc_re_r      <= '0;
      dc_im_r      <= '0;
      time_r       <= TW'(drs_pkg::START_TIME_RST);
      phase_r      <= '0;
      seen_r       <= '0;
      wptr_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          drs_pkg::REG_TIME_STEP:  time_step_r  <= cfg_data[25:0];
          drs_pkg::REG_START_TIME: time_r       <= TW'(cfg_data);
          drs_pkg::REG_ECHO_RE:    echo_re_r    <= cfg_data[15:0];
          drs_pkg::REG_ECHO_IM:    echo_im_r    <= cfg_data[15:0];
          drs_pkg::REG_PHASE_STEP: phase_step_r <= cfg_data;
          drs_pkg::REG_GAIN:       gain_r       <= cfg_data[15:0];
          drs_pkg::REG_DC_RE:      dc_re_r      <= cfg_data[15:0];
          drs_pkg::REG_DC_IM:      dc_im_r      <= cfg_data[15:0];
        endcase
      end
      if (cmd.store && seen_r != '1) begin
        seen_r <= seen_r + 32'd1;
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (cmd.adv) begin
        time_r  <= time_r + TW'(time_step_r);
        phase_r <= phase_r + phase_step_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && seen_r != '1) begin
      hist_mem[wptr_r] <= {in_q, in_i};
    end
    if (cmd.rd) begin
      rdm_r <= hist_mem[fm[AW-1:0]];
      rde_r <= hist_mem[fe[AW-1:0]];
      vm_r  <= fm[AW];
      ve_r  <= fe[AW];
      idx_r <= cmd.rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef1) begin
      a_r <= {17'b0, u17} * {17'b0, om17};
      b_r <= {18'b0, op17} * {17'b0, tm18};
      for (int j = 0; j < 4; j++) begin
        acc_r[j] <= '0;
      end
    end
    if (cmd.coef2) begin
      p_r[0] <= {20'b0, a_r} * {36'b0, tm18};
      p_r[1] <= t1 + {t1[52:0], 1'b0};
      p_r[2] <= t2 + {t2[52:0], 1'b0};
      p_r[3] <= {20'b0, a_r} * {37'b0, op17};
    end
    if (cmd.coef3) begin
      for (int j = 0; j < 4; j++) begin
        c_r[j] <= c_nxt[j];
      end
    end
    if (cmd.mac) begin
      acc_r[0] <= acc_r[0] + ys[0] * c_r[idx_r];
      acc_r[1] <= acc_r[1] + ys[1] * c_r[idx_r];
      acc_r[2] <= acc_r[2] + ys[2] * c_r[idx_r];
      acc_r[3] <= acc_r[3] + ys[3] * c_r[idx_r];
    end
    if (cmd.rnd) begin
      for (int j = 0; j < 4; j++) begin
        ip_r[j] <= 20'(((acc_r[j] + 37'sd32768) >>> 16));
      end
    end
    if (cmd.echo) begin
      sr_r <= {{2{ip_r[0][19]}}, ip_r[0]} + re_t[36:15];
      si_r <= {{2{ip_r[1][19]}}, ip_r[1]} + im_t[36:15];
    end
    if (cmd.mix) begin
      mr_r <= mr_t[39:15];
      mi_r <= mi_t[39:15];
    end
    if (cmd.gain) begin
      res_i_r <= sat16(gr_s);
      res_q_r <= sat16(gi_s);
    end
    if (cmd.load_out) begin
      out_i_r    <= res_i_r;
      out_q_r    <= res_q_r;
      out_last_r <= cmd.last;
    end
  end

  assign out_i    = out_i_r;
  assign out_q    = out_q_r;
  assign out_last = out_last_r;

endmodule
`default_nettype wire

@@ rtl/core/drs_ctrl.sv @@
`default_nettype none
module drs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output drs_pkg::dp_cmd_t      cmd,
  input  wire drs_pkg::dp_sts_t sts
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CHK  = 5'd1;
  localparam logic [4:0] ST_C1   = 5'd2;
  localparam logic [4:0] ST_C2   = 5'd3;
  localparam logic [4:0] ST_C3   = 5'd4;
  localparam logic [4:0] ST_R0   = 5'd5;
  localparam logic [4:0] ST_R1   = 5'd6;
  localparam logic [4:0] ST_R2   = 5'd7;
  localparam logic [4:0] ST_R3   = 5'd8;
  localparam logic [4:0] ST_M4   = 5'd9;
  localparam logic [4:0] ST_RND  = 5'd10;
  localparam logic [4:0] ST_ECH  = 5'd11;
  localparam logic [4:0] ST_MIX  = 5'd12;
  localparam logic [4:0] ST_GN   = 5'd13;
  localparam logic [4:0] ST_ADV  = 5'd14;
  localparam logic [4:0] ST_WO   = 5'd15;

  logic [4:0] state_r, state_nxt;
  logic [1:0] n_r, n_nxt;
  logic       ov_r, ov_nxt;
  logic       last;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    n_nxt     = n_r;
    ov_nxt    = ov_r && !out_ready;
    last      = !(n_r == 2'd1 && sts.win_rdy);
    cmd.last  = last;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.store = 1'b1;
          n_nxt     = '0;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK:  state_nxt = sts.win_rdy ? ST_C1 : ST_IDLE;
      ST_C1: begin
        cmd.coef1     = 1'b1;
        cmd.sin_start = 1'b1;
        state_nxt     = ST_C2;
      end
      ST_C2: begin
        cmd.coef2 = 1'b1;
        state_nxt = ST_C3;
      end
      ST_C3: begin
        cmd.coef3 = 1'b1;
        state_nxt = ST_R0;
      end
      ST_R0: begin
        cmd.rd     = 1'b1;
        cmd.rd_idx = 2'd0;
        state_nxt  = ST_R1;
      end
      ST_R1: begin
        cmd.rd     = 1'b1;
        cmd.rd_idx = 2'd1;
        cmd.mac    = 1'b1;
        state_nxt  = ST_R2;
      end
      ST_R2: begin
        cmd.rd     = 1'b1;
        cmd.rd_idx = 2'd2;
        cmd.mac    = 1'b1;
        state_nxt  = ST_R3;
      end
      ST_R3: begin
        cmd.rd     = 1'b1;
        cmd.rd_idx = 2'd3;
        cmd.mac    = 1'b1;
        state_nxt  = ST_M4;
      end
      ST_M4: begin
        cmd.mac   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_ECH;
      end
      ST_ECH: begin
        cmd.echo  = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        if (sts.sin_done) begin
          cmd.mix   = 1'b1;
          state_nxt = ST_GN;
        end
      end
      ST_GN: begin
        cmd.gain  = 1'b1;
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        cmd.adv   = 1'b1;
        n_nxt     = n_r + 2'd1;
        state_nxt = ST_WO;
      end
      ST_WO: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = last ? ST_IDLE : ST_C1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ov_r;

endmodule
`default_nettype wire

@@ rtl/core/drifting_resampler_channel_unit.sv @@
// Drifting resampler channel: fractional-delay cubic resampler with echo,
// NCO mixing, gain and DC offset on a complex 16-bit sample stream.
// Input channel (in_valid/in_ready, in_i/in_q): one baseband sample per
// transaction. Each sample causes zero, one or two result transactions on
// the output channel (out_valid/out_ready, out_i/out_q); out_last_of_run
// marks the last result caused by that sample.
// Configuration channel (cfg_valid/cfg_ready, cfg_index/cfg_data) is always
// ready; write it only while the block is idle. Writing start_time also
// reloads the output time.
// The sequencer walks one result at a time through coefficient, history
// read (two reads per cycle), echo, mix and gain steps.
// A new sample is taken once the last result of the previous one has been
// loaded into the output register.
// While the receiver stalls, a finished result waits in the output register
// and the next result waits in the datapath.
// Reset returns history count, output time (to the start_time reset value),
// NCO phase, config and control state to reset values; no clearing pass.
`default_nettype none
module drifting_resampler_channel_unit #(
  parameter int SAMPLES_PER_SYMBOL = drs_pkg::SPS_DEF,
  parameter int HISTORY_DEPTH      = drs_pkg::DEPTH_DEF,
  parameter int TIME_FRACTION_BITS = drs_pkg::TFB_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_i,
  input  wire logic signed [15:0] in_q,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_i,
  output logic signed [15:0]      out_q,
  output logic                    out_last_of_run,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  drs_pkg::dp_cmd_t cmd;
  drs_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  drs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  drs_datapath #(
    .SPS   (SAMPLES_PER_SYMBOL),
    .DEPTH (HISTORY_DEPTH),
    .TFB   (TIME_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_i      (in_i),
    .in_q      (in_q),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_i     (out_i),
    .out_q     (out_q),
    .out_last  (out_last_of_run)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  a_sine_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sin_start |=> !sts.sin_done)
    else $error("stale NCO value after start");

  a_mix_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mix |-> sts.sin_done)
    else $error("mix before NCO value ready");

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 95;
  localparam int EXP_DEPTH      = 1024;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
    logic               last;
  } sample_out_t;

  typedef struct {
    logic signed [15:0] i;
    logic signed [15:0] q;
    bit                 typed;
    logic signed [15:0] ei;
    logic signed [15:0] eq;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_i = '0;
  logic signed [15:0] in_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_i;
  logic signed [15:0] out_q;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  drifting_resampler_channel_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_i(in_i), .in_q(in_q),
    .out_valid(out_valid), .out_ready(out_ready), .out_i(out_i), .out_q(out_q),
    .out_last_of_run(out_last_of_run),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // resampler model state
  bit [25:0] m_step = drs_pkg::TIME_STEP_RST;
  bit [31:0] m_start = drs_pkg::START_TIME_RST;
  longint m_echo_re = 0, m_echo_im = 0, m_dc_re = 0, m_dc_im = 0;
  bit [31:0] m_phase_step = '0;
  longint m_gain = drs_pkg::GAIN_RST;
  bit [31:0] m_hist [16];
  bit [31:0] m_seen = '0;
  bit [55:0] m_time = 56'(drs_pkg::START_TIME_RST);
  bit [31:0] m_phase = '0;

  // expected results, ring with free-running write and read counts
  sample_out_t exp_buf [EXP_DEPTH];
  int exp_wr = 0, exp_rd = 0;
  int in_idle = 0, out_idle = 0;
  int mismatches = 0, results_seen = 0, samples_sent = 0, two_out_items = 0;
  int quiet_cycles = 0, hold_cnt = 0;
  bit hold_req = 1'b0;

  stim_row_t stim_table [24] = '{
    '{-16'sd32768, -16'sd32768, 1'b1, -16'sd32768, 16'sd32767},
    '{16'sd32767, 16'sd32767, 1'b1, -16'sd32768, 16'sd32767},
    '{16'sd0, 16'sd0, 1'b1, -16'sd32768, 16'sd32767},
    '{-16'sd1, 16'sd1, 1'b1, -16'sd32768, 16'sd32767},
    '{16'sd32767, -16'sd32768, 1'b1, -16'sd32768, 16'sd32767},
    '{-16'sd32768, 16'sd32767, 1'b1, -16'sd32768, 16'sd32767},
    '{16'sh5555, -16'sh5556, 1'b1, -16'sd32768, 16'sd32767},
    '{-16'sh5556, 16'sh5555, 1'b1, -16'sd32768, 16'sd32767},
    '{16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{16'sd32767, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd32768, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{16'sd1000, -16'sd1000, 1'b0, 16'sd0, 16'sd0},
    '{16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{16'sd32767, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
    '{16'sd12345, -16'sd23456, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0},
    '{16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{-16'sd32768, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0}
  };

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint nco_sin(longint x);
    longint w, p, r;
    w = (x * x) >>> 30;
    p = 172272;
    p = -5026995 + ((p * w) >>> 30);
    p = 85569306 + ((p * w) >>> 30);
    p = -693598668 + ((p * w) >>> 30);
    p = 1686629713 + ((p * w) >>> 30);
    r = (((p * x) >>> 30) + 16384) >>> 15;
    if (r < 0) r = 0;
    if (r > 32767) r = 32767;
    return r;
  endfunction

  function automatic void history_at(longint k, output longint si, output longint sq);
    bit [31:0] w;
    si = 0;
    sq = 0;
    if (k < 0 || k >= longint'(m_seen)) return;
    if (longint'(m_seen) - k > 16) return;
    w = m_hist[k % 16];
    si = longint'($signed(w[15:0]));
    sq = longint'($signed(w[31:16]));
  endfunction

  function automatic void lagrange(longint ti, longint c [4], output longint ri,
                                   output longint rq);
    longint ai, aq, yi, yq;
    ai = 0;
    aq = 0;
    for (int j = 0; j < 4; j++) begin
      history_at(ti - 1 + j, yi, yq);
      ai += yi * c[j];
      aq += yq * c[j];
    end
    ri = (ai + 32768) >>> 16;
    rq = (aq + 32768) >>> 16;
  endfunction

  function automatic int resample_sample(logic signed [15:0] si, logic signed [15:0] sq);
    longint ti, u, p0, p1, p2, p3, d, h;
    longint c [4];
    longint ai, aq, bi, bq, sr, sm, s, co, lr, li, mr, mi;
    sample_out_t res;
    int n;
    n = 0;
    d = longint'(6) << 32;
    h = longint'(3) << 32;
    if (m_seen != 32'hFFFF_FFFF) begin
      m_hist[m_seen % 16] = {sq, si};
      m_seen++;
    end
    while (n < 2) begin
      ti = longint'(m_time >> 24);
      if (ti + 3 > longint'(m_seen)) break;
      u = longint'(m_time[23:8]);
      p0 = u * (65536 - u) * (131072 - u);
      p1 = 3 * (u + 65536) * (65536 - u) * (131072 - u);
      p2 = 3 * (u + 65536) * u * (131072 - u);
      p3 = (u + 65536) * u * (65536 - u);
      c[0] = -((p0 + h) / d);
      c[1] = (p1 + h) / d;
      c[2] = (p2 + h) / d;
      c[3] = -((p3 + h) / d);
      lagrange(ti, c, ai, aq);
      lagrange(ti - 4, c, bi, bq);
      sr = ai + ((m_echo_re * bi - m_echo_im * bq + 16384) >>> 15);
      sm = aq + ((m_echo_re * bq + m_echo_im * bi + 16384) >>> 15);
      s = nco_sin(longint'(m_phase[29:0]));
      co = nco_sin(longint'(32'h4000_0000) - longint'(m_phase[29:0]));
      case (m_phase[31:30])
        2'd0: begin lr = co; li = s; end
        2'd1: begin lr = -s; li = co; end
        2'd2: begin lr = -co; li = -s; end
        default: begin lr = s; li = -co; end
      endcase
      mr = (sr * lr - sm * li + 16384) >>> 15;
      mi = (sr * li + sm * lr + 16384) >>> 15;
      res.i = 16'(sat16(((mr * m_gain + 2048) >>> 12) + m_dc_re));
      res.q = 16'(sat16(((mi * m_gain + 2048) >>> 12) + m_dc_im));
      res.last = 1'b0;
      exp_buf[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
      m_phase += m_phase_step;
      m_time += 56'(m_step);
      n++;
    end
    if (n > 0) exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
    return n;
  endfunction

  // receiver, checker and watchdog
  always @(posedge clk) begin
    sample_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (exp_wr == exp_rd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: i=%0d q=%0d last=%0b", out_i, out_q,
                     out_last_of_run);
        end else begin
          e = exp_buf[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_i !== e.i || out_q !== e.q || out_last_of_run !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected i=%0d q=%0d last=%0b, got i=%0d q=%0d last=%0b",
                       e.i, e.q, e.last, out_i, out_q, out_last_of_run);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL drifting_resampler_channel_unit");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      drs_pkg::REG_TIME_STEP: m_step = data[25:0];
      drs_pkg::REG_START_TIME: begin
        m_start = data;
        m_time = 56'(data);
      end
      drs_pkg::REG_ECHO_RE: m_echo_re = longint'($signed(data[15:0]));
      drs_pkg::REG_ECHO_IM: m_echo_im = longint'($signed(data[15:0]));
      drs_pkg::REG_PHASE_STEP: m_phase_step = data;
      drs_pkg::REG_GAIN: m_gain = longint'(data[15:0]);
      drs_pkg::REG_DC_RE: m_dc_re = longint'($signed(data[15:0]));
      drs_pkg::REG_DC_IM: m_dc_im = longint'($signed(data[15:0]));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq, output int n);
    while ($urandom_range(99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_i <= si;
    in_q <= sq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = resample_sample(si, sq);
    samples_sent++;
    if (n == 2) two_out_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_field();
    case ($urandom_range(15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int n, base;
    logic [31:0] v;
    for (int k = 0; k < 16; k++) m_hist[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gain zero: every output equals the DC offset
    cfg_write(drs_pkg::REG_GAIN, 32'd0);
    cfg_write(drs_pkg::REG_DC_RE, 32'hFFFF_8000);
    cfg_write(drs_pkg::REG_DC_IM, 32'd32767);
    cfg_write(drs_pkg::REG_START_TIME, 32'd0);
    for (int r = 0; r < 24; r++) begin
      if (r == 8) begin
        drain();
        // frozen time: two outputs per sample
        cfg_write(drs_pkg::REG_GAIN, 32'd65535);
        cfg_write(drs_pkg::REG_DC_RE, 32'd0);
        cfg_write(drs_pkg::REG_DC_IM, 32'd0);
        cfg_write(drs_pkg::REG_ECHO_RE, 32'hFFFF_8000);
        cfg_write(drs_pkg::REG_ECHO_IM, 32'd32767);
        cfg_write(drs_pkg::REG_TIME_STEP, 32'd0);
        cfg_write(drs_pkg::REG_PHASE_STEP, 32'h4000_0000);
      end else if (r == 16) begin
        drain();
        cfg_write(drs_pkg::REG_TIME_STEP, 32'h03FF_FFFF);
        cfg_write(drs_pkg::REG_START_TIME, 32'hFFFF_FFFF);
        cfg_write(drs_pkg::REG_ECHO_RE, 32'd32767);
        cfg_write(drs_pkg::REG_ECHO_IM, 32'hFFFF_8000);
        cfg_write(drs_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
        cfg_write(drs_pkg::REG_GAIN, 32'd4096);
        cfg_write(drs_pkg::REG_DC_RE, 32'd32767);
        cfg_write(drs_pkg::REG_DC_IM, 32'hFFFF_8000);
      end
      base = exp_wr;
      send_sample(stim_table[r].i, stim_table[r].q, n);
      if (stim_table[r].typed)
        for (int k = base; k < base + n; k++) begin
          exp_buf[k % EXP_DEPTH].i = stim_table[r].ei;
          exp_buf[k % EXP_DEPTH].q = stim_table[r].eq;
        end
    end
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        in_idle = 13;
        out_idle = 83;
      end else if (ph < 6) begin
        in_idle = 83;
        out_idle = 13;
      end else begin
        in_idle = 0;
        out_idle = 0;
      end
      case ($urandom_range(9))
        0: v = 32'd0;
        1: v = 32'h03FF_FFFF;
        default: v = $urandom_range(33554432, 8388608);
      endcase
      cfg_write(drs_pkg::REG_TIME_STEP, v);
      case ($urandom_range(9))
        0: v = 32'd0;
        1: v = 32'hFFFF_FFFF;
        default: v = ((m_seen + $urandom_range(6)) << 24) | ($urandom() & 32'hFF_FFFF);
      endcase
      cfg_write(drs_pkg::REG_START_TIME, v);
      cfg_write(drs_pkg::REG_ECHO_RE,
                ($urandom_range(3) == 0) ? 32'd0 : 32'($signed(rand_field())));
      cfg_write(drs_pkg::REG_ECHO_IM,
                ($urandom_range(3) == 0) ? 32'd0 : 32'($signed(rand_field())));
      cfg_write(drs_pkg::REG_PHASE_STEP, $urandom());
      case ($urandom_range(7))
        0: v = 32'd0;
        1: v = 32'd65535;
        default: v = $urandom_range(8192, 1024);
      endcase
      cfg_write(drs_pkg::REG_GAIN, v);
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(5) == 0) v = 32'($signed(rand_field()));
        else v = 32'($signed($urandom_range(512) - 256));
        cfg_write(k ? drs_pkg::REG_DC_IM : drs_pkg::REG_DC_RE, v);
      end
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        if (ph == 4 && it == 5) hold_req = 1'b1;
        if (ph == 7 && it == 50) drain();
        send_sample(rand_field(), rand_field(), n);
      end
      drain();
    end

    $display("covered %0d samples and %0d results over %0d configurations", samples_sent,
             results_seen, RAND_PHASES + 3);
    $display("%0d samples produced two results, %0d mismatches", two_out_items, mismatches);
    if (mismatches == 0) begin
      $display("PASS drifting_resampler_channel_unit");
    end else begin
      $display("FAIL drifting_resampler_channel_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
